>>> rtl/core/gps_pkg.sv
// Shared types, constants and helpers for the ground point to screen projector.
// Used by the top level and the xform, scale and divider modules; has no dependencies of its own.
package gps_pkg;

  localparam int COEF_FRAC_DEFAULT = 16;
  localparam int DIV_BITS = 32;
  localparam int D_W = 34;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  localparam logic [7:0] REG_WIDTH = 8'd0;
  localparam logic [7:0] REG_HEIGHT = 8'd1;

  localparam logic [13:0] WIDTH_RESET = 14'd1920;
  localparam logic [13:0] HEIGHT_RESET = 14'd1080;

  typedef struct packed {
    logic cmd;
    logic [4:0] idx;
    logic signed [31:0] coef;
    logic signed [31:0] px;
    logic signed [31:0] pz;
  } gps_item_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cw;
  } gps_clip_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [D_W-1:0] d;
    logic [DIV_BITS-1:0] q;
    logic neg;
    logic ovf;
  } gps_lane_t;

  typedef struct packed {
    gps_lane_t x;
    gps_lane_t y;
    logic pv;
  } gps_div_t;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic pv;
  } gps_res_t;

  // Clamp a wide signed sum to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ground_point_to_screen_top.sv
// Top level of the ground point to screen projector: ports, window registers, stage chain.
// Depends on gps_pkg, gps_xform, gps_scale and gps_div.
//
//  Channel | Direction | Beat contents
//  s_      | in        | tuser: cmd; tdata: matrix_index, coef_value, point_x, point_z
//  m_      | out       | tuser: proj_valid; tdata: screen_x, screen_y
//  cfg_    | in        | cfg_index, cfg_data (14 bits used); always ready
//
// One beat is taken per cycle while nothing stalls; a projection result passes through
// four matrix stages, three scaling stages, one stage per quotient bit of the
// 32-bit divider, and the output register.
// Load beats write the coefficient stores as they pass the stage that reads them.
// Reset clears all stage valid bits and restores the window size registers.
// Every stage holds while the one after it is full and stalled, so an empty
// stage lets a new beat in even while a finished result waits on m_tready.
module ground_point_to_screen_top import gps_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // matrix_index[4:0], coef_value[36:5], point_x[68:37], point_z[100:69]
  input  logic [0:0]   s_tuser,   // cmd[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // screen_x[31:0], screen_y[63:32]
  output logic [0:0]   m_tuser,   // proj_valid[0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [13:0] win_w, win_h;
  gps_item_t item;
  gps_clip_t clip;
  gps_div_t  dv;
  gps_res_t  res;
  logic xv, xr, sv, sr;

  // Window size registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      win_w <= WIDTH_RESET;
      win_h <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) win_w <= cfg_data[13:0];
      if (cfg_index == REG_HEIGHT) win_h <= cfg_data[13:0];
    end
  end

  // Unpack the input beat.
  always_comb begin
    item.cmd = s_tuser[0];
    item.idx = s_tdata[4:0];
    item.coef = s_tdata[36:5];
    item.px = s_tdata[68:37];
    item.pz = s_tdata[100:69];
  end

  gps_xform #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_xform (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_item(item),
    .out_valid(xv), .out_ready(xr), .out_clip(clip)
  );

  gps_scale u_scale (
    .clk(clk), .rst(rst), .win_w(win_w), .win_h(win_h),
    .in_valid(xv), .in_ready(xr), .in_clip(clip),
    .out_valid(sv), .out_ready(sr), .out_div(dv)
  );

  gps_div u_div (
    .clk(clk), .rst(rst),
    .in_valid(sv), .in_ready(sr), .in_div(dv),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {res.sy, res.sx};
  assign m_tuser = res.pv;

endmodule

>>> rtl/core/gps_xform.sv
// View and projection matrix stages with the two coefficient stores.
// Depends on gps_pkg.
module gps_xform import gps_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  gps_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output gps_clip_t out_clip
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (COEF_FRAC_BITS - 1);

  logic signed [31:0] view_m [16];
  logic signed [31:0] proj_m [16];

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;
  logic cmd1, cmd2, cmd3, cmd4;
  logic [4:0] idx1, idx2;
  logic signed [31:0] coef1, coef2;
  logic signed [63:0] pv [4][3];
  logic signed [31:0] vw [4];
  logic signed [63:0] pp [3][4];
  gps_clip_t clip4;

  logic signed [63:0] tv [4][3];
  logic signed [63:0] tp [3][4];
  logic signed [31:0] vw_next [4];
  logic signed [31:0] cl_next [3];

  // Ready chain; a load item leaves quietly after the last stage.
  always_comb begin
    r4 = !v4 || (cmd4 != CMD_PROJECT) || out_ready;
    r3 = !v3 || r4;
    r2 = !v2 || r3;
    r1 = !v1 || r2;
  end
  assign in_ready = r1;
  assign out_valid = v4 && (cmd4 == CMD_PROJECT);
  assign out_clip = clip4;

  // Rounding and row sums of both matrices.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        tv[r][c] = (pv[r][c] + HALF) >>> COEF_FRAC_BITS;
      end
      vw_next[r] = sat32({{2{tv[r][0][63]}}, tv[r][0]} + {{2{tv[r][1][63]}}, tv[r][1]}
                         + {{2{tv[r][2][63]}}, tv[r][2]});
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        tp[r][c] = (pp[r][c] + HALF) >>> COEF_FRAC_BITS;
      end
      cl_next[r] = sat32({{2{tp[r][0][63]}}, tp[r][0]} + {{2{tp[r][1][63]}}, tp[r][1]}
                         + {{2{tp[r][2][63]}}, tp[r][2]} + {{2{tp[r][3][63]}}, tp[r][3]});
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  // Stage one: view products; a load beat writes the view store here.
  always_ff @(posedge clk) begin
    if (r1) begin
      cmd1 <= in_item.cmd;
      idx1 <= in_item.idx;
      coef1 <= in_item.coef;
      for (int r = 0; r < 4; r++) begin
        pv[r][0] <= view_m[r] * in_item.px;
        pv[r][1] <= view_m[8 + r] * in_item.pz;
        pv[r][2] <= view_m[12 + r] * 64'sd65536;
      end
      if (in_valid && in_item.cmd == CMD_LOAD && !in_item.idx[4]) begin
        view_m[in_item.idx[3:0]] <= in_item.coef;
      end
    end
  end

  // Stage two: view-space vector.
  always_ff @(posedge clk) begin
    if (r2) begin
      cmd2 <= cmd1;
      idx2 <= idx1;
      coef2 <= coef1;
      for (int r = 0; r < 4; r++) vw[r] <= vw_next[r];
    end
  end

  // Stage three: projection products for rows x, y and w; loads write here.
  always_ff @(posedge clk) begin
    if (r3) begin
      cmd3 <= cmd2;
      for (int c = 0; c < 4; c++) begin
        pp[0][c] <= proj_m[c * 4] * vw[c];
        pp[1][c] <= proj_m[c * 4 + 1] * vw[c];
        pp[2][c] <= proj_m[c * 4 + 3] * vw[c];
      end
      if (v2 && cmd2 == CMD_LOAD && idx2[4]) begin
        proj_m[idx2[3:0]] <= coef2;
      end
    end
  end

  // Stage four: clip coordinates.
  always_ff @(posedge clk) begin
    if (r4) begin
      cmd4 <= cmd3;
      clip4.cx <= cl_next[0];
      clip4.cy <= cl_next[1];
      clip4.cw <= cl_next[2];
    end
  end

endmodule

>>> rtl/core/gps_scale.sv
// Screen scaling stages: numerators, magnitudes and the quotient range check.
// Depends on gps_pkg.
module gps_scale import gps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [13:0] win_w,
  input  logic [13:0] win_h,
  input  logic        in_valid,
  output logic        in_ready,
  input  gps_clip_t   in_clip,
  output logic        out_valid,
  input  logic        out_ready,
  output gps_div_t    out_div
);

  logic v5, v6, v7;
  logic r5, r6, r7;
  logic signed [47:0] nx5, ny5;
  logic signed [31:0] w5;
  logic [63:0] n6x, n6y;
  logic [D_W-1:0] d6;
  logic negx6, negy6, pv6;
  gps_div_t dv7;

  logic signed [33:0] sx_sum, sy_sum;
  logic [46:0] ax, ay;
  logic [31:0] aw;
  logic [66:0] dlim;

  always_comb begin
    r7 = !v7 || out_ready;
    r6 = !v6 || r7;
    r5 = !v5 || r6;
  end
  assign in_ready = r5;
  assign out_valid = v7;
  assign out_div = dv7;

  always_comb begin
    sx_sum = 34'(in_clip.cx) + 34'(in_clip.cw);
    sy_sum = 34'(in_clip.cw) - 34'(in_clip.cy);
    ax = nx5[47] ? 47'(-nx5) : nx5[46:0];
    ay = ny5[47] ? 47'(-ny5) : ny5[46:0];
    aw = w5[31] ? 32'(-w5) : w5;
    dlim = {1'b0, d6, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (r5) v5 <= in_valid;
      if (r6) v6 <= v5;
      if (r7) v7 <= v6;
    end
  end

  // Stage five: (cx + cw) * W and (cw - cy) * H.
  always_ff @(posedge clk) begin
    if (r5) begin
      nx5 <= sx_sum * $signed({1'b0, win_w});
      ny5 <= sy_sum * $signed({1'b0, win_h});
      w5 <= in_clip.cw;
    end
  end

  // Stage six: dividend |n| * 2^16 + |w| and divisor 2|w| with the half scale folded in.
  always_ff @(posedge clk) begin
    if (r6) begin
      n6x <= {ax, 16'd0} + 64'(aw);
      n6y <= {ay, 16'd0} + 64'(aw);
      d6 <= {1'b0, aw, 1'b0};
      negx6 <= nx5[47] ^ w5[31];
      negy6 <= ny5[47] ^ w5[31];
      pv6 <= (w5 != 32'sd0);
    end
  end

  // Stage seven: flag quotients that cannot fit in 32 bits.
  always_ff @(posedge clk) begin
    if (r7) begin
      dv7.x.rem <= n6x;
      dv7.y.rem <= n6y;
      dv7.x.d <= d6;
      dv7.y.d <= d6;
      dv7.x.q <= '0;
      dv7.y.q <= '0;
      dv7.x.neg <= negx6;
      dv7.y.neg <= negy6;
      dv7.x.ovf <= {3'b0, n6x} >= dlim;
      dv7.y.ovf <= {3'b0, n6y} >= dlim;
      dv7.pv <= pv6;
    end
  end

endmodule

>>> rtl/core/gps_div.sv
// Two-lane restoring divider, one quotient bit per stage, and the saturating output stage.
// Depends on gps_pkg.
module gps_div import gps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  gps_div_t in_div,
  output logic     out_valid,
  input  logic     out_ready,
  output gps_res_t out_res
);

  localparam int NS = DIV_BITS;

  logic     v [1:NS];
  logic     rdy [1:NS + 1];
  gps_div_t st [1:NS];
  gps_div_t st_next [1:NS];
  logic     ov;
  gps_res_t res;

  // One trial subtraction per lane for quotient bit NS - k.
  function automatic gps_div_t trial(input gps_div_t s, input int k);
    gps_div_t o;
    logic [67:0] tx, ty;
    o = s;
    tx = {4'b0, s.x.rem} - ({34'b0, s.x.d} << (NS - k));
    ty = {4'b0, s.y.rem} - ({34'b0, s.y.d} << (NS - k));
    if (!tx[67]) begin
      o.x.rem = tx[63:0];
      o.x.q[NS - k] = 1'b1;
    end
    if (!ty[67]) begin
      o.y.rem = ty[63:0];
      o.y.q[NS - k] = 1'b1;
    end
    return o;
  endfunction

  always_comb begin
    rdy[NS + 1] = !ov || out_ready;
    for (int k = NS; k >= 1; k--) rdy[k] = !v[k] || rdy[k + 1];
  end
  assign in_ready = rdy[1];

  // Stage one takes the incoming beat; later stages take the stage before.
  always_comb begin
    st_next[1] = trial(in_div, 1);
    for (int k = 2; k <= NS; k++) st_next[k] = trial(st[k - 1], k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NS; k++) v[k] <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int k = 2; k <= NS; k++) if (rdy[k]) v[k] <= v[k - 1];
      if (rdy[NS + 1]) ov <= v[NS];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NS; k++) if (rdy[k]) st[k] <= st_next[k];
  end

  // Sign, saturation and the invalid case.
  function automatic logic [31:0] finish(input gps_lane_t l, input logic pv);
    logic [31:0] r;
    if (!pv) begin
      r = '0;
    end else if (l.neg) begin
      r = (l.ovf || l.q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-l.q);
    end else begin
      r = (l.ovf || l.q[31]) ? 32'h7FFF_FFFF : l.q;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rdy[NS + 1]) begin
      res.sx <= finish(st[NS].x, st[NS].pv);
      res.sy <= finish(st[NS].y, st[NS].pv);
      res.pv <= st[NS].pv;
    end
  end

  assign out_valid = ov;
  assign out_res = res;

endmodule

>>> rtl/core/gps_checker.sv
// Port-level checks for the ground point to screen projector, bound to the top level.
// Depends on ground_point_to_screen_top.
module gps_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic [0:0]   m_tuser,
  input logic         cfg_valid,
  input logic         cfg_ready
);

  // Nothing comes out in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // An invalid projection carries zero coordinates.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
    else $error("invalid projection with nonzero coordinates");

  // Register writes are never held off.
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind ground_point_to_screen_top gps_checker u_gps_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
